>>> sv/trtm_pkg.sv
// ----------------------------------------------------------------------------
// trtm_pkg: shared types and constants of the typed range table
// Range entry layout, outcome codes and default sizes.
// ----------------------------------------------------------------------------
package trtm_pkg;

  // default sizes
  localparam int DefBankSlots     = 16;
  localparam int DefRangesPerBank = 32;

  // reset value of the cartridge bank count register
  localparam logic [3:0] CartBankCountRst = 4'd1;

  // one stored range
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] first;
    logic [15:0] last;
  } span_t;

  localparam int SpanW = $bits(span_t);

  // result codes
  typedef enum logic [2:0] {
    OC_REJECT  = 3'd0,
    OC_TOGGLE  = 3'd1,
    OC_INSERT  = 3'd2,
    OC_COVERED = 3'd3,
    OC_FULL    = 3'd4
  } outcome_e;

endpackage

>>> sv/trtm_ram.sv
// ----------------------------------------------------------------------------
// trtm_ram: generic single write port RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module trtm_ram #(
  parameter int Width = 34,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/trtm_seq.sv
// ----------------------------------------------------------------------------
// trtm_seq: range update sequencer
// Walks one bank list through the store RAM with a shared entry compare unit,
// builds the new list in a work RAM and copies it back with merge fix-ups.
// ----------------------------------------------------------------------------
module trtm_seq #(
  parameter int BANK_SLOTS      = trtm_pkg::DefBankSlots,
  parameter int RANGES_PER_BANK = trtm_pkg::DefRangesPerBank
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          range_kind_i,
  input  logic [15:0]         range_first_i,
  input  logic [15:0]         range_last_i,
  input  logic signed [4:0]   bank_choice_i,
  input  logic                pc_in_cartridge_i,
  input  logic [3:0]          current_bank_i,
  input  logic [3:0]          cart_bank_count_i,
  input  logic                res_free_i,
  output logic                idle_o,
  output logic                done_o,
  output trtm_pkg::outcome_e  outcome_o
);

  import trtm_pkg::*;

  localparam int SW  = (BANK_SLOTS > 1) ? $clog2(BANK_SLOTS) : 1;
  localparam int AW  = $clog2(BANK_SLOTS * RANGES_PER_BANK);
  localparam int WAW = $clog2(RANGES_PER_BANK + 2);
  localparam int CW  = $clog2(RANGES_PER_BANK + 1);
  localparam int MW  = $clog2(RANGES_PER_BANK + 3);

  typedef enum logic [3:0] {
    S_IDLE, S_MATCH_RD, S_MATCH_CHK, S_SHIFT_RD, S_SHIFT_WR,
    S_BUILD_RD, S_BUILD_CHK, S_BUILD_B, S_MERGE, S_WB_RD, S_WB_WR, S_FIN
  } state_e;

  state_e        state_q;
  outcome_e      outc_q;
  logic          done_q;
  logic [1:0]    kind_q;
  logic [15:0]   f_q, l_q;
  logic [SW-1:0] slot_q;
  logic [CW-1:0] n_q;
  logic [MW-1:0] j_q, m_q, pos_q, mf_q;
  logic          cut_q, found_q, hprev_q, lft_q, rgt_q;
  span_t         prev_q, rent_q, b_q;
  logic [CW-1:0] cnt_q [BANK_SLOTS];

  // RAM ports
  logic           st_we, wk_we;
  logic [AW-1:0]  st_waddr, st_raddr, base;
  logic [WAW-1:0] wk_waddr, wk_raddr;
  span_t          st_wdata, wk_wdata, st_rdata, wk_rdata;
  logic [SpanW-1:0] st_rbits, wk_rbits;

  assign st_rdata = span_t'(st_rbits);
  assign wk_rdata = span_t'(wk_rbits);

  trtm_ram #(.Width(SpanW), .Depth(BANK_SLOTS * RANGES_PER_BANK)) u_store (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(st_raddr), .rdata_o(st_rbits)
  );

  trtm_ram #(.Width(SpanW), .Depth(RANGES_PER_BANK + 2)) u_work (
    .clk_i, .we_i(wk_we), .waddr_i(wk_waddr), .wdata_i(wk_wdata),
    .raddr_i(wk_raddr), .rdata_o(wk_rbits)
  );

  // slot choice for a new word
  logic [3:0]    slot4, slot_c;
  logic [SW-1:0] slot_in;
  logic          reject;

  always_comb begin
    if (bank_choice_i[4]) begin
      slot4 = pc_in_cartridge_i ? current_bank_i : cart_bank_count_i;
    end else begin
      slot4 = bank_choice_i[3:0];
    end
    slot_c = (slot4 > cart_bank_count_i) ? cart_bank_count_i : slot4;
    if (int'(slot_c) > BANK_SLOTS - 1) begin
      slot_in = SW'(BANK_SLOTS - 1);
    end else begin
      slot_in = SW'(slot_c);
    end
    reject = (range_last_i < range_first_i) || (range_first_i == 16'd0) ||
             (range_last_i == 16'd0);
  end

  // shared entry compare unit
  span_t ent, pa, pb, ptr;
  logic  cov, con, same, ha, hb, hit;

  always_comb begin
    ent  = st_rdata;
    cov  = (f_q <= ent.first) && (l_q >= ent.last);
    con  = (f_q >= ent.first) && (l_q <= ent.last);
    same = (ent.kind == kind_q);
    hit  = same && (ent.first == f_q) && (ent.last == l_q);
    ha   = f_q > ent.first;
    hb   = l_q < ent.last;
    pa   = ent;
    pa.last = f_q - 16'd1;
    pb   = ent;
    pb.first = l_q + 16'd1;
    ptr  = ent;
    if ((f_q >= ent.first) && (f_q <= ent.last)) begin
      ptr.last = f_q - 16'd1;
    end else if ((l_q >= ent.first) && (l_q <= ent.last)) begin
      ptr.first = l_q + 16'd1;
    end
  end

  // merge decision and copy-back source
  logic [MW-1:0] jp1, src, mf_c;
  logic          ovr, lft_c, rgt_c;
  span_t         oval;

  always_comb begin
    rgt_c = found_q && (rent_q.kind == kind_q) &&
            ({1'b0, l_q} + 17'd1 == {1'b0, rent_q.first});
    lft_c = hprev_q && (prev_q.kind == kind_q) &&
            ({1'b0, prev_q.last} + 17'd1 == {1'b0, f_q});
    if (lft_c && rgt_c) begin
      mf_c = m_q - MW'(1);
    end else if (!lft_c && !rgt_c) begin
      mf_c = m_q + MW'(1);
    end else begin
      mf_c = m_q;
    end

    jp1  = j_q + MW'(1);
    src  = j_q;
    ovr  = 1'b0;
    oval = '{kind: kind_q, first: f_q, last: l_q};
    if (lft_q && rgt_q) begin
      if (jp1 == pos_q) begin
        ovr  = 1'b1;
        oval = '{kind: kind_q, first: prev_q.first, last: rent_q.last};
      end else if (jp1 > pos_q) begin
        src = jp1;
      end
    end else if (rgt_q) begin
      if (j_q == pos_q) begin
        ovr  = 1'b1;
        oval = '{kind: kind_q, first: f_q, last: rent_q.last};
      end
    end else if (lft_q) begin
      if (jp1 == pos_q) begin
        ovr  = 1'b1;
        oval = '{kind: kind_q, first: prev_q.first, last: l_q};
      end
    end else begin
      if (j_q == pos_q) begin
        ovr = 1'b1;
      end else if (j_q > pos_q) begin
        src = j_q - MW'(1);
      end
    end
  end

  // RAM control
  always_comb begin
    base     = AW'(slot_q) * AW'(RANGES_PER_BANK);
    st_we    = 1'b0;
    st_waddr = base + AW'(j_q);
    st_wdata = st_rdata;
    st_raddr = base + AW'(j_q);
    wk_we    = 1'b0;
    wk_waddr = m_q[WAW-1:0];
    wk_wdata = ent;
    wk_raddr = src[WAW-1:0];
    case (state_q)
      S_SHIFT_WR: begin
        st_we    = 1'b1;
        st_waddr = base + AW'(j_q) - AW'(1);
      end
      S_BUILD_CHK: begin
        if (cut_q) begin
          wk_we = 1'b1;
        end else if (cov) begin
          wk_we = 1'b0;
        end else if (con) begin
          if (!same) begin
            wk_we    = ha || hb;
            wk_wdata = ha ? pa : pb;
          end
        end else begin
          wk_we    = 1'b1;
          wk_wdata = ptr;
        end
      end
      S_BUILD_B: begin
        wk_we    = 1'b1;
        wk_wdata = b_q;
      end
      S_WB_RD: begin
        st_we    = ovr && (j_q != mf_q);
        st_wdata = oval;
      end
      S_WB_WR: begin
        st_we    = 1'b1;
        st_wdata = wk_rdata;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      outc_q  <= OC_REJECT;
      done_q  <= 1'b0;
      cut_q   <= 1'b0;
      found_q <= 1'b0;
      hprev_q <= 1'b0;
      lft_q   <= 1'b0;
      rgt_q   <= 1'b0;
      j_q     <= '0;
      m_q     <= '0;
      pos_q   <= '0;
      mf_q    <= '0;
      n_q     <= '0;
      slot_q  <= '0;
      for (int i = 0; i < BANK_SLOTS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      done_q <= (state_q == S_FIN) && res_free_i;
      // track insert position while the work list is built
      if (wk_we && !found_q) begin
        if (l_q < wk_wdata.first) begin
          found_q <= 1'b1;
          pos_q   <= m_q;
          rent_q  <= wk_wdata;
        end else begin
          prev_q  <= wk_wdata;
          hprev_q <= 1'b1;
        end
      end
      if (wk_we) begin
        m_q <= m_q + MW'(1);
      end
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            kind_q  <= range_kind_i;
            f_q     <= range_first_i;
            l_q     <= range_last_i;
            slot_q  <= slot_in;
            n_q     <= cnt_q[slot_in];
            j_q     <= '0;
            m_q     <= '0;
            cut_q   <= 1'b0;
            found_q <= 1'b0;
            hprev_q <= 1'b0;
            if (reject) begin
              outc_q  <= OC_REJECT;
              state_q <= S_FIN;
            end else begin
              state_q <= S_MATCH_RD;
            end
          end
        end
        S_MATCH_RD: begin
          if (j_q == MW'(n_q)) begin
            j_q     <= '0;
            state_q <= S_BUILD_RD;
          end else begin
            state_q <= S_MATCH_CHK;
          end
        end
        S_MATCH_CHK: begin
          j_q <= j_q + MW'(1);
          state_q <= hit ? S_SHIFT_RD : S_MATCH_RD;
        end
        S_SHIFT_RD: begin
          if (j_q == MW'(n_q)) begin
            cnt_q[slot_q] <= n_q - CW'(1);
            outc_q        <= OC_TOGGLE;
            state_q       <= S_FIN;
          end else begin
            state_q <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          j_q     <= j_q + MW'(1);
          state_q <= S_SHIFT_RD;
        end
        S_BUILD_RD: begin
          state_q <= (j_q == MW'(n_q)) ? S_MERGE : S_BUILD_CHK;
        end
        S_BUILD_CHK: begin
          j_q <= j_q + MW'(1);
          if (!cut_q && !cov && con && same) begin
            outc_q  <= OC_COVERED;
            state_q <= S_FIN;
          end else if (!cut_q && !cov && con) begin
            cut_q   <= 1'b1;
            b_q     <= pb;
            state_q <= (ha && hb) ? S_BUILD_B : S_BUILD_RD;
          end else begin
            state_q <= S_BUILD_RD;
          end
        end
        S_BUILD_B: begin
          state_q <= S_BUILD_RD;
        end
        S_MERGE: begin
          if (!found_q) begin
            pos_q <= m_q;
          end
          lft_q <= lft_c;
          rgt_q <= rgt_c;
          mf_q  <= mf_c;
          j_q   <= '0;
          if (mf_c > MW'(RANGES_PER_BANK)) begin
            outc_q  <= OC_FULL;
            state_q <= S_FIN;
          end else begin
            state_q <= S_WB_RD;
          end
        end
        S_WB_RD: begin
          if (j_q == mf_q) begin
            cnt_q[slot_q] <= CW'(mf_q);
            outc_q        <= OC_INSERT;
            state_q       <= S_FIN;
          end else if (ovr) begin
            j_q <= j_q + MW'(1);
          end else begin
            state_q <= S_WB_WR;
          end
        end
        S_WB_WR: begin
          j_q     <= j_q + MW'(1);
          state_q <= S_WB_RD;
        end
        S_FIN: begin
          if (res_free_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign idle_o    = (state_q == S_IDLE) && !done_q;
  assign done_o    = done_q;
  assign outcome_o = outc_q;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (n_q <= CW'(RANGES_PER_BANK)))
    else $error("bank list count above capacity");

  a_work_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wk_we |-> (m_q <= MW'(RANGES_PER_BANK)))
    else $error("work list overrun");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result without return to idle");

  a_store_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_we && (state_q == S_WB_RD || state_q == S_WB_WR)) |->
      (mf_q <= MW'(RANGES_PER_BANK)))
    else $error("store write on a full list");

endmodule

>>> sv/typed_range_table_merge.sv
// ----------------------------------------------------------------------------
// typed_range_table_merge: typed address range table, one list per bank
// Configuration register, word handshake and result register.
// ----------------------------------------------------------------------------
// Each word runs a match scan of the bank list, then either a shift pass that
// removes the matching entry or a rebuild pass into the work RAM and a
// copy-back pass, each stepping one entry through a RAM with a registered
// read. Rejected words skip the passes. in_ready_o is high only while the
// sequencer is idle; a finished word may wait in the result register while
// the next word is taken. cart_bank_count is to be written only while idle;
// the block itself does not enforce this.
module typed_range_table_merge #(
  parameter int BANK_SLOTS      = trtm_pkg::DefBankSlots,
  parameter int RANGES_PER_BANK = trtm_pkg::DefRangesPerBank
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          range_kind_i,
  input  logic [15:0]         range_first_i,
  input  logic [15:0]         range_last_i,
  input  logic signed [4:0]   bank_choice_i,
  input  logic                pc_in_cartridge_i,
  input  logic [3:0]          current_bank_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          outcome_o
);

  import trtm_pkg::*;

  logic [3:0] cbc_q;
  logic       out_valid_q;
  logic [2:0] outcome_q;
  logic       idle, done;
  outcome_e   res;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cbc_q <= CartBankCountRst;
    end else if (cfg_we_i) begin
      cbc_q <= cfg_wdata_i;
    end
  end

  trtm_seq #(.BANK_SLOTS(BANK_SLOTS), .RANGES_PER_BANK(RANGES_PER_BANK)) u_seq (
    .clk_i, .rst_ni,
    .start_i(in_valid_i && idle),
    .range_kind_i, .range_first_i, .range_last_i, .bank_choice_i,
    .pc_in_cartridge_i, .current_bank_i,
    .cart_bank_count_i(cbc_q),
    .res_free_i(!out_valid_q || out_ready_i),
    .idle_o(idle), .done_o(done), .outcome_o(res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      outcome_q <= 3'(res);
    end
  end

  assign in_ready_o  = idle;
  assign out_valid_o = out_valid_q;
  assign outcome_o   = outcome_q;

endmodule
